/* rtl/tre_pkg.sv */
// shared types and constants for the tcp rto estimator
// item structs, operation and register codes, controller states and commands
// no dependencies
package tre_pkg;

  // widths fixed by the item and register formats
  localparam int unsigned SeqW     = 32;
  localparam int unsigned RttW     = 24;
  localparam int unsigned RtoW     = 16;
  localparam int unsigned GainW    = 9;
  localparam int unsigned MultW    = 5;
  localparam int unsigned GranW    = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  // product widths: gain times 24-bit value, k times variance
  localparam int unsigned ProdW    = GainW + RttW;
  localparam int unsigned TermW    = MultW + RttW;
  localparam int unsigned RsumW    = TermW + 1;

  // register reset values and the full gain
  localparam logic [GainW-1:0] AlphaReset    = 9'd32;
  localparam logic [GainW-1:0] BetaReset     = 9'd64;
  localparam logic [GainW-1:0] GainFull      = 9'd256;
  localparam logic [MultW-1:0] MultReset     = 5'd4;
  localparam logic [GranW-1:0] GranReset     = 10'd1;
  localparam logic [RtoW-1:0]  RtoFloorReset = 16'd1000;
  localparam logic [RtoW-1:0]  RtoCeilReset  = 16'd60000;
  localparam logic [RtoW-1:0]  RtoInitReset  = 16'd3000;

  // operation codes
  typedef enum logic [2:0] {
    OP_MEAS_START = 3'd0,
    OP_ACK        = 3'd1,
    OP_RETX       = 3'd2,
    OP_START      = 3'd3,
    OP_START_DBL  = 3'd4,
    OP_STOP       = 3'd5,
    OP_RESTART    = 3'd6,
    OP_TICK       = 3'd7
  } tre_op_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_TIMER_READY = 3'd0,
    REG_ALPHA       = 3'd1,
    REG_BETA        = 3'd2,
    REG_VAR_MULT    = 3'd3,
    REG_GRANULARITY = 3'd4,
    REG_RTO_FLOOR   = 3'd5,
    REG_RTO_CEILING = 3'd6,
    REG_RTO_INITIAL = 3'd7
  } tre_reg_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_VMUL,
    ST_VSUM,
    ST_SSUM,
    ST_TERM,
    ST_RSUM,
    ST_CLAMP,
    ST_EMIT
  } tre_state_e;

  // input item
  typedef struct packed {
    logic [2:0]      operation;
    logic [SeqW-1:0] seq_number;
  } tre_in_t;

  // result item
  typedef struct packed {
    logic            accepted;
    logic            timer_expired;
    logic            measuring;
    logic            timer_running;
    logic [RttW-1:0] smoothed_rtt;
    logic [RtoW-1:0] current_rto;
  } tre_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic vmul;
    logic vsum;
    logic ssum;
    logic term;
    logic rsum;
    logic clamp;
    logic emit;
  } tre_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic ack_hit;
    logic first_sample;
  } tre_status_t;

endpackage

/* rtl/tre_ctrl.sv */
// controller state machine of the tcp rto estimator
// sequences item capture, execution, the rtt sample steps and result hand-off
// depends on tre_pkg
module tre_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_free_i,
  input  tre_pkg::tre_status_t status_i,
  output tre_pkg::tre_cmd_t    cmd_o
);
  import tre_pkg::*;

  tre_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (status_i.ack_hit) begin
          state_d = status_i.first_sample ? ST_TERM : ST_VMUL;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_VMUL:  state_d = ST_VSUM;
      ST_VSUM:  state_d = ST_SSUM;
      ST_SSUM:  state_d = ST_TERM;
      ST_TERM:  state_d = ST_RSUM;
      ST_RSUM:  state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC:  cmd_o.exec  = 1'b1;
      ST_VMUL:  cmd_o.vmul  = 1'b1;
      ST_VSUM:  cmd_o.vsum  = 1'b1;
      ST_SSUM:  cmd_o.ssum  = 1'b1;
      ST_TERM:  cmd_o.term  = 1'b1;
      ST_RSUM:  cmd_o.rsum  = 1'b1;
      ST_CLAMP: cmd_o.clamp = 1'b1;
      ST_EMIT:  cmd_o.emit  = out_free_i;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/tre_dp.sv */
// datapath of the tcp rto estimator
// configuration registers, measure and timer state, srtt/rttvar/rto arithmetic
// depends on tre_pkg
module tre_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tre_pkg::tre_cmd_t            cmd_i,
  input  tre_pkg::tre_in_t             in_data_i,
  input  logic                         cfg_we_i,
  input  logic [tre_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tre_pkg::CfgDataW-1:0] cfg_wdata_i,
  output tre_pkg::tre_status_t         status_o,
  output tre_pkg::tre_out_t            result_o
);
  import tre_pkg::*;

  // configuration registers
  logic             ready_q, ready_d;
  logic [GainW-1:0] alpha_q, alpha_d;
  logic [GainW-1:0] beta_q, beta_d;
  logic [MultW-1:0] kmul_q, kmul_d;
  logic [GranW-1:0] gran_q, gran_d;
  logic [RtoW-1:0]  floor_q, floor_d;
  logic [RtoW-1:0]  ceil_q, ceil_d;
  logic [RtoW-1:0]  init_q, init_d;

  // estimator state
  logic [RttW-1:0]  srtt_q, srtt_d;
  logic [RttW-1:0]  var_q, var_d;
  logic [RtoW-1:0]  rto_q, rto_d;
  logic             valid_q, valid_d;
  logic             m_act_q, m_act_d;
  logic [SeqW-1:0]  mseq_q, mseq_d;
  logic [RttW-1:0]  elapsed_q, elapsed_d;
  logic             t_act_q, t_act_d;
  logic [RtoW-1:0]  t_rem_q, t_rem_d;

  // item and arithmetic payload registers
  tre_op_e          op_q, op_d;
  logic [SeqW-1:0]  seq_q, seq_d;
  logic             ok_q, ok_d;
  logic             exp_q, exp_d;
  logic [RttW-1:0]  diff_q, diff_d;
  logic [ProdW-1:0] p0_q, p0_d;
  logic [ProdW-1:0] p1_q, p1_d;
  logic [TermW-1:0] term_q, term_d;
  logic [RsumW-1:0] rsum_q, rsum_d;

  // helpers
  logic [SeqW-1:0]  ack_delta;
  logic             seq_hit;
  logic [GainW-1:0] a_eff, b_eff;
  logic [ProdW:0]   prod_sum;
  logic [TermW-1:0] term_max;
  logic [RsumW-1:0] rto_floored;
  logic [RtoW:0]    rto_doubled;

  // wrap-aware greater-than of the ack against the measured sequence number
  assign ack_delta = seq_q - mseq_q;
  assign seq_hit   = m_act_q && (ack_delta != '0) && !ack_delta[SeqW-1];

  assign status_o.ack_hit      = (op_q == OP_ACK) && seq_hit;
  assign status_o.first_sample = !valid_q;

  // gains limited to one
  assign a_eff = (alpha_q > GainFull) ? GainFull : alpha_q;
  assign b_eff = (beta_q > GainFull) ? GainFull : beta_q;

  assign prod_sum    = {1'b0, p0_q} + {1'b0, p1_q};
  assign term_max    = (term_q < TermW'(gran_q)) ? TermW'(gran_q) : term_q;
  assign rto_floored = (rsum_q < RsumW'(floor_q)) ? RsumW'(floor_q) : rsum_q;
  assign rto_doubled = {rto_q, 1'b0};

  // next state
  always_comb begin
    ready_d   = ready_q;
    alpha_d   = alpha_q;
    beta_d    = beta_q;
    kmul_d    = kmul_q;
    gran_d    = gran_q;
    floor_d   = floor_q;
    ceil_d    = ceil_q;
    init_d    = init_q;
    srtt_d    = srtt_q;
    var_d     = var_q;
    rto_d     = rto_q;
    valid_d   = valid_q;
    m_act_d   = m_act_q;
    mseq_d    = mseq_q;
    elapsed_d = elapsed_q;
    t_act_d   = t_act_q;
    t_rem_d   = t_rem_q;
    op_d      = op_q;
    seq_d     = seq_q;
    ok_d      = ok_q;
    exp_d     = exp_q;
    diff_d    = diff_q;
    p0_d      = p0_q;
    p1_d      = p1_q;
    term_d    = term_q;
    rsum_d    = rsum_q;

    // capture the item
    if (cmd_i.load) begin
      op_d  = tre_op_e'(in_data_i.operation);
      seq_d = in_data_i.seq_number;
    end

    // apply the operation
    if (cmd_i.exec) begin
      ok_d  = 1'b0;
      exp_d = 1'b0;
      case (op_q)
        OP_MEAS_START: begin
          if (!m_act_q) begin
            m_act_d   = 1'b1;
            mseq_d    = seq_q;
            elapsed_d = '0;
            ok_d      = 1'b1;
          end
        end
        OP_ACK: begin
          if (seq_hit) begin
            m_act_d = 1'b0;
            ok_d    = 1'b1;
            diff_d  = (srtt_q > elapsed_q) ? (srtt_q - elapsed_q) : (elapsed_q - srtt_q);
            // first sample seeds the estimator
            if (!valid_q) begin
              srtt_d  = elapsed_q;
              var_d   = elapsed_q >> 1;
              valid_d = 1'b1;
            end
          end
        end
        OP_RETX: begin
          // karn: a retransmission voids the running measure
          if (seq_hit) begin
            m_act_d = 1'b0;
            ok_d    = 1'b1;
          end
        end
        OP_START: begin
          if (ready_q && !t_act_q) begin
            t_act_d = 1'b1;
            t_rem_d = rto_q;
            ok_d    = 1'b1;
          end
        end
        OP_START_DBL: begin
          if (ready_q && !t_act_q) begin
            if (rto_doubled > (RtoW+1)'(ceil_q)) begin
              rto_d   = ceil_q;
              t_rem_d = ceil_q;
            end else begin
              rto_d   = rto_doubled[RtoW-1:0];
              t_rem_d = rto_doubled[RtoW-1:0];
            end
            t_act_d = 1'b1;
            ok_d    = 1'b1;
          end
        end
        OP_STOP: begin
          if (ready_q && t_act_q) begin
            t_act_d = 1'b0;
            t_rem_d = '0;
            ok_d    = 1'b1;
          end
        end
        OP_RESTART: begin
          // stop then start collapses to a reload when the timer is set up
          if (ready_q) begin
            t_act_d = 1'b1;
            t_rem_d = rto_q;
            ok_d    = 1'b1;
          end
        end
        OP_TICK: begin
          ok_d = 1'b1;
          if (m_act_q && (elapsed_q != '1)) begin
            elapsed_d = elapsed_q + RttW'(1);
          end
          if (t_act_q) begin
            if (t_rem_q <= RtoW'(1)) begin
              t_rem_d = '0;
              t_act_d = 1'b0;
              exp_d   = 1'b1;
            end else begin
              t_rem_d = t_rem_q - RtoW'(1);
            end
          end
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end

    // variance products against the old srtt
    if (cmd_i.vmul) begin
      p0_d = ProdW'(GainFull - b_eff) * ProdW'(var_q);
      p1_d = ProdW'(b_eff) * ProdW'(diff_q);
    end

    // new variance, then the srtt products
    if (cmd_i.vsum) begin
      var_d = prod_sum[RttW+7:8];
      p0_d  = ProdW'(GainFull - a_eff) * ProdW'(srtt_q);
      p1_d  = ProdW'(a_eff) * ProdW'(elapsed_q);
    end

    // new srtt
    if (cmd_i.ssum) begin
      srtt_d = prod_sum[RttW+7:8];
    end

    // variance term of the rto
    if (cmd_i.term) begin
      term_d = TermW'(kmul_q) * TermW'(var_q);
    end

    if (cmd_i.rsum) begin
      rsum_d = RsumW'(srtt_q) + RsumW'(term_max);
    end

    // floor first, ceiling wins
    if (cmd_i.clamp) begin
      rto_d = (rto_floored > RsumW'(ceil_q)) ? ceil_q : rto_floored[RtoW-1:0];
    end

    // configuration writes
    if (cfg_we_i) begin
      case (tre_reg_e'(cfg_idx_i))
        REG_TIMER_READY: begin
          ready_d = cfg_wdata_i[0];
          if (!cfg_wdata_i[0]) begin
            t_act_d = 1'b0;
            t_rem_d = '0;
          end
        end
        REG_ALPHA:       alpha_d = cfg_wdata_i[GainW-1:0];
        REG_BETA:        beta_d  = cfg_wdata_i[GainW-1:0];
        REG_VAR_MULT:    kmul_d  = cfg_wdata_i[MultW-1:0];
        REG_GRANULARITY: gran_d  = cfg_wdata_i[GranW-1:0];
        REG_RTO_FLOOR:   floor_d = cfg_wdata_i[RtoW-1:0];
        REG_RTO_CEILING: ceil_d  = cfg_wdata_i[RtoW-1:0];
        REG_RTO_INITIAL: begin
          init_d = cfg_wdata_i[RtoW-1:0];
          if (!valid_q) rto_d = cfg_wdata_i[RtoW-1:0];
        end
        default: ready_d = ready_q;
      endcase
    end
  end

  // configuration and estimator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q   <= 1'b1;
      alpha_q   <= AlphaReset;
      beta_q    <= BetaReset;
      kmul_q    <= MultReset;
      gran_q    <= GranReset;
      floor_q   <= RtoFloorReset;
      ceil_q    <= RtoCeilReset;
      init_q    <= RtoInitReset;
      srtt_q    <= '0;
      var_q     <= '0;
      rto_q     <= RtoInitReset;
      valid_q   <= 1'b0;
      m_act_q   <= 1'b0;
      mseq_q    <= '0;
      elapsed_q <= '0;
      t_act_q   <= 1'b0;
      t_rem_q   <= '0;
    end else begin
      ready_q   <= ready_d;
      alpha_q   <= alpha_d;
      beta_q    <= beta_d;
      kmul_q    <= kmul_d;
      gran_q    <= gran_d;
      floor_q   <= floor_d;
      ceil_q    <= ceil_d;
      init_q    <= init_d;
      srtt_q    <= srtt_d;
      var_q     <= var_d;
      rto_q     <= rto_d;
      valid_q   <= valid_d;
      m_act_q   <= m_act_d;
      mseq_q    <= mseq_d;
      elapsed_q <= elapsed_d;
      t_act_q   <= t_act_d;
      t_rem_q   <= t_rem_d;
    end
  end

  // item and arithmetic payload
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    seq_q  <= seq_d;
    ok_q   <= ok_d;
    exp_q  <= exp_d;
    diff_q <= diff_d;
    p0_q   <= p0_d;
    p1_q   <= p1_d;
    term_q <= term_d;
    rsum_q <= rsum_d;
  end

  // result of the item just executed
  assign result_o.accepted      = ok_q;
  assign result_o.timer_expired = exp_q;
  assign result_o.measuring     = m_act_q;
  assign result_o.timer_running = t_act_q;
  assign result_o.smoothed_rtt  = srtt_q;
  assign result_o.current_rto   = rto_q;

endmodule

/* rtl/tcp_rto_estimator.sv */
// TCP retransmission timeout estimator with rtt measurement and a one-shot
// timer. One operation per item, one result item per operation. Most items
// pass capture, execute and hand-off to reach the output register; an ack
// that ends a measure adds the rto term, sum and clamp, and after the first
// sample the gain products and sums ahead of them, each registered in the
// datapath. A new item is taken as soon as the previous result sits in the
// output register, even while it waits. Configuration registers are to be
// written through cfg_we_i/cfg_idx_i/cfg_wdata_i only while no item is in
// flight, not enforced by the block; writing 0 to timer_ready stops the timer
// top level: instantiates tre_ctrl and tre_dp, holds the output register
// depends on tre_pkg
module tcp_rto_estimator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tre_pkg::tre_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tre_pkg::tre_out_t            out_data_o,
  input  logic                         cfg_we_i,
  input  logic [tre_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tre_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import tre_pkg::*;

  tre_cmd_t    cmd;
  tre_status_t status;
  tre_out_t    result;
  logic        out_free;
  logic        out_valid_q, out_valid_d;
  tre_out_t    out_q, out_d;

  assign out_free = !out_valid_q || out_ready_i;

  // controller
  tre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  tre_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_o    (status),
    .result_o    (result)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd.emit) begin
      out_valid_d = 1'b1;
      out_d       = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* bench/tb_tcp_rto_estimator.sv */
// testbench for tcp_rto_estimator: directed and random operation items
// checked against an in-bench estimator model, with random idling on both sides
// depends on tre_pkg and the tcp_rto_estimator rtl
module tb_tcp_rto_estimator;
  import tre_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned MaxPrinted   = 40;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  tre_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  tre_out_t            out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // estimator state as seen by the bench
  logic [RttW-1:0] est_srtt, est_var, meas_ticks;
  logic [RtoW-1:0] est_rto, tmr_left;
  logic [SeqW-1:0] meas_seq;
  logic            est_srtt_seen, meas_on, tmr_on;

  // register copies
  logic             reg_ready;
  logic [GainW-1:0] reg_alpha, reg_beta;
  logic [MultW-1:0] reg_kmult;
  logic [GranW-1:0] reg_gran;
  logic [RtoW-1:0]  reg_floor, reg_ceil, reg_init;

  tre_out_t    status_q[$];
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_left   = 0;
  bit          idling       = 1'b1;

  tcp_rto_estimator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls in bursts of random length while idling is on
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 7);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MaxPrinted)
      $display("mismatch on result %0d, %s: got %0d, expected %0d",
               results_seen, what, got, want);
  endtask

  // compare each result item with the oldest prediction
  always @(posedge clk_i) begin : check_results
    tre_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_q.size() == 0) begin
        report_mismatch("unexpected item", 32'd1, 32'd0);
      end else begin
        want = status_q.pop_front();
        if (out_data_o.accepted !== want.accepted)
          report_mismatch("accepted", 32'(out_data_o.accepted), 32'(want.accepted));
        if (out_data_o.timer_expired !== want.timer_expired)
          report_mismatch("timer_expired", 32'(out_data_o.timer_expired),
                          32'(want.timer_expired));
        if (out_data_o.measuring !== want.measuring)
          report_mismatch("measuring", 32'(out_data_o.measuring), 32'(want.measuring));
        if (out_data_o.timer_running !== want.timer_running)
          report_mismatch("timer_running", 32'(out_data_o.timer_running),
                          32'(want.timer_running));
        if (out_data_o.smoothed_rtt !== want.smoothed_rtt)
          report_mismatch("smoothed_rtt", 32'(out_data_o.smoothed_rtt),
                          32'(want.smoothed_rtt));
        if (out_data_o.current_rto !== want.current_rto)
          report_mismatch("current_rto", 32'(out_data_o.current_rto),
                          32'(want.current_rto));
      end
      results_seen++;
    end
  end

  // load the retransmission timer from the current rto
  function automatic logic arm_timer();
    if (!reg_ready || tmr_on) return 1'b0;
    tmr_on   = 1'b1;
    tmr_left = est_rto;
    return 1'b1;
  endfunction

  function automatic logic disarm_timer();
    if (!reg_ready || !tmr_on) return 1'b0;
    tmr_on   = 1'b0;
    tmr_left = '0;
    return 1'b1;
  endfunction

  // apply one operation to the bench state and return the status it leaves
  function automatic tre_out_t step_estimator(input tre_op_e op, input logic [SeqW-1:0] seq);
    tre_out_t        res;
    logic            ok, fired;
    logic [SeqW-1:0] seq_gap;
    logic [RtoW:0]   dbl;
    logic [63:0]     ga, gb, diff, prod, term, rto_sum;
    ok      = 1'b0;
    fired   = 1'b0;
    seq_gap = seq - meas_seq;
    case (op)
      OP_MEAS_START: begin
        if (!meas_on) begin
          meas_on    = 1'b1;
          meas_seq   = seq;
          meas_ticks = '0;
          ok         = 1'b1;
        end
      end
      OP_ACK: begin
        if (meas_on && seq_gap != 0 && !seq_gap[SeqW-1]) begin
          meas_on = 1'b0;
          ok      = 1'b1;
          // first sample seeds srtt and half of it as variance
          if (!est_srtt_seen) begin
            est_srtt      = meas_ticks;
            est_var       = meas_ticks >> 1;
            est_srtt_seen = 1'b1;
          end else begin
            ga = 64'(reg_alpha);
            gb = 64'(reg_beta);
            if (ga > 64'(GainFull)) ga = 64'(GainFull);
            if (gb > 64'(GainFull)) gb = 64'(GainFull);
            diff = (est_srtt > meas_ticks) ? 64'(est_srtt - meas_ticks)
                                           : 64'(meas_ticks - est_srtt);
            prod = (64'd256 - gb) * 64'(est_var) + gb * diff;
            est_var = prod[RttW+7:8];
            prod = (64'd256 - ga) * 64'(est_srtt) + ga * 64'(meas_ticks);
            est_srtt = prod[RttW+7:8];
          end
          term = 64'(reg_kmult) * 64'(est_var);
          if (term < 64'(reg_gran)) term = 64'(reg_gran);
          rto_sum = 64'(est_srtt) + term;
          if (rto_sum < 64'(reg_floor)) rto_sum = 64'(reg_floor);
          if (rto_sum > 64'(reg_ceil)) rto_sum = 64'(reg_ceil);
          est_rto = rto_sum[RtoW-1:0];
        end
      end
      OP_RETX: begin
        // karn: a retransmission covering the measured seq drops the measure
        if (meas_on && seq_gap != 0 && !seq_gap[SeqW-1]) begin
          meas_on = 1'b0;
          ok      = 1'b1;
        end
      end
      OP_START: ok = arm_timer();
      OP_START_DBL: begin
        if (reg_ready && !tmr_on) begin
          dbl = {est_rto, 1'b0};
          if (dbl > {1'b0, reg_ceil}) dbl = {1'b0, reg_ceil};
          est_rto = dbl[RtoW-1:0];
          ok = arm_timer();
        end
      end
      OP_STOP: ok = disarm_timer();
      OP_RESTART: begin
        void'(disarm_timer());
        ok = arm_timer();
      end
      default: begin
        ok = 1'b1;
        if (meas_on && meas_ticks != {RttW{1'b1}}) meas_ticks = meas_ticks + 1'b1;
        if (tmr_on) begin
          if (tmr_left <= 1) begin
            tmr_left = '0;
            tmr_on   = 1'b0;
            fired    = 1'b1;
          end else begin
            tmr_left = tmr_left - 1'b1;
          end
        end
      end
    endcase
    res.accepted      = ok;
    res.timer_expired = fired;
    res.measuring     = meas_on;
    res.timer_running = tmr_on;
    res.smoothed_rtt  = est_srtt;
    res.current_rto   = est_rto;
    return res;
  endfunction

  // send one item, with a random gap in front of it while idling is on
  task automatic send_item(input tre_op_e op, input logic [SeqW-1:0] seq);
    tre_in_t item;
    item.operation  = op;
    item.seq_number = seq;
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    status_q.push_back(step_estimator(op, seq));
    items_sent++;
  endtask

  // hold off the sender until every outstanding result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input tre_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_TIMER_READY: begin
        reg_ready = val[0];
        if (!val[0]) begin
          tmr_on   = 1'b0;
          tmr_left = '0;
        end
      end
      REG_ALPHA:       reg_alpha = val[GainW-1:0];
      REG_BETA:        reg_beta  = val[GainW-1:0];
      REG_VAR_MULT:    reg_kmult = val[MultW-1:0];
      REG_GRANULARITY: reg_gran  = val[GranW-1:0];
      REG_RTO_FLOOR:   reg_floor = val;
      REG_RTO_CEILING: reg_ceil  = val;
      default: begin
        reg_init = val;
        if (!est_srtt_seen) est_rto = val;
      end
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned ready, alpha, beta, kmult, gran,
                            floor_ms, ceil_ms, init_ms);
    drain();
    cfg_write(REG_TIMER_READY, CfgDataW'(ready));
    cfg_write(REG_ALPHA, CfgDataW'(alpha));
    cfg_write(REG_BETA, CfgDataW'(beta));
    cfg_write(REG_VAR_MULT, CfgDataW'(kmult));
    cfg_write(REG_GRANULARITY, CfgDataW'(gran));
    cfg_write(REG_RTO_FLOOR, CfgDataW'(floor_ms));
    cfg_write(REG_RTO_CEILING, CfgDataW'(ceil_ms));
    cfg_write(REG_RTO_INITIAL, CfgDataW'(init_ms));
  endtask

  // mostly well-formed measure and timer sequences, some noise
  task automatic random_traffic(input int unsigned n_items);
    int unsigned     stop_at, k;
    logic [SeqW-1:0] mseq;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          mseq = $urandom;
          send_item(OP_MEAS_START, mseq);
          k = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 10);
          repeat (k) begin
            if ($urandom_range(0, 7) == 0)
              send_item(tre_op_e'($urandom_range(OP_START, OP_RESTART)), $urandom);
            else
              send_item(OP_TICK, $urandom);
          end
          case ($urandom_range(0, 5))
            0:       send_item(OP_RETX, mseq + $urandom_range(1, 32'h7fff_ffff));
            1:       send_item(OP_ACK, mseq - $urandom_range(0, 32'h8000_0000));
            default: send_item(OP_ACK, mseq + $urandom_range(1, 32'h7fff_ffff));
          endcase
        end
        5, 6: begin
          send_item(tre_op_e'($urandom_range(OP_START, OP_RESTART)), $urandom);
          repeat ($urandom_range(0, 24)) send_item(OP_TICK, $urandom);
          if ($urandom_range(0, 1) == 1) send_item(OP_STOP, $urandom);
        end
        default: send_item(tre_op_e'($urandom_range(OP_MEAS_START, OP_TICK)), $urandom);
      endcase
    end
  endtask

  task automatic random_config();
    set_config(($urandom_range(0, 7) != 0),
               ($urandom_range(0, 3) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256),
               ($urandom_range(0, 3) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256),
               $urandom_range(0, 31),
               ($urandom_range(0, 1) == 1) ? $urandom_range(0, 8) : $urandom_range(0, 1023),
               ($urandom_range(0, 1) == 1) ? $urandom_range(0, 30) : $urandom_range(0, 65535),
               ($urandom_range(0, 1) == 1) ? $urandom_range(0, 40) : $urandom_range(0, 65535),
               $urandom_range(0, 65535));
  endtask

  // rto_initial before any sample, timer expiry and doubling from a short rto
  task automatic test_initial_rto();
    cfg_write(REG_RTO_INITIAL, 16'd5);
    send_item(OP_START, 32'd0);
    repeat (6) send_item(OP_TICK, 32'hffff_ffff);
    send_item(OP_START_DBL, 32'd0);
    send_item(OP_STOP, 32'd0);
    drain();
    cfg_write(REG_RTO_INITIAL, RtoInitReset);
  endtask

  // every operation, refusals, wrap-aware compare, zero-length first sample
  task automatic test_operations();
    send_item(OP_TICK, 32'd0);
    send_item(OP_ACK, 32'd1);
    send_item(OP_RETX, 32'd1);
    send_item(OP_STOP, 32'd0);
    send_item(OP_MEAS_START, 32'hffff_fff0);
    send_item(OP_MEAS_START, 32'd0);
    send_item(OP_ACK, 32'hffff_fff0);
    send_item(OP_ACK, 32'h7fff_fff0);
    send_item(OP_ACK, 32'd5);
    send_item(OP_MEAS_START, 32'd0);
    send_item(OP_TICK, 32'd0);
    send_item(OP_TICK, 32'd0);
    send_item(OP_ACK, 32'd0);
    send_item(OP_RETX, 32'hffff_ffff);
    send_item(OP_RETX, 32'd1);
    send_item(OP_START, 32'd0);
    send_item(OP_START, 32'd0);
    send_item(OP_START_DBL, 32'd0);
    send_item(OP_RESTART, 32'd0);
    send_item(OP_STOP, 32'd0);
    send_item(OP_STOP, 32'd0);
    send_item(OP_START_DBL, 32'hffff_ffff);
    send_item(OP_RESTART, 32'd0);
    drain();
  endtask

  // clearing timer_ready stops the timer and refuses timer operations
  task automatic test_timer_ready();
    cfg_write(REG_TIMER_READY, CfgDataW'(0));
    send_item(OP_START, 32'd0);
    send_item(OP_STOP, 32'd0);
    send_item(OP_RESTART, 32'd0);
    send_item(OP_START_DBL, 32'd0);
    send_item(OP_TICK, 32'd0);
    drain();
    cfg_write(REG_TIMER_READY, CfgDataW'(1));
  endtask

  // register extremes: zero and full gains, gains above full, floor over ceiling
  task automatic test_config_extremes();
    set_config(1, 0, 0, 0, 0, 0, 65535, 0);
    random_traffic(100);
    set_config(1, 256, 256, 31, 1023, 0, 65535, 65535);
    random_traffic(100);
    set_config(1, 511, 300, 16, 1, 65535, 100, 3000);
    random_traffic(100);
    set_config(1, 32, 64, 4, 1, 0, 0, 1);
    random_traffic(100);
    set_config(1, 257, 1, 1, 0, 5, 20, 7);
    random_traffic(100);
  endtask

  task automatic test_random();
    repeat (5) begin
      random_config();
      random_traffic(160);
    end
  endtask

  // closing stretch without idling on either side
  task automatic test_no_idling();
    random_config();
    idling = 1'b0;
    random_traffic(150);
  endtask

  initial begin
    est_srtt      = '0;
    est_var       = '0;
    est_rto       = RtoInitReset;
    est_srtt_seen = 1'b0;
    meas_on       = 1'b0;
    meas_seq      = '0;
    meas_ticks    = '0;
    tmr_on        = 1'b0;
    tmr_left      = '0;
    reg_ready     = 1'b1;
    reg_alpha     = AlphaReset;
    reg_beta      = BetaReset;
    reg_kmult     = MultReset;
    reg_gran      = GranReset;
    reg_floor     = RtoFloorReset;
    reg_ceil      = RtoCeilReset;
    reg_init      = RtoInitReset;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_initial_rto();
    test_operations();
    test_timer_ready();
    test_config_extremes();
    test_random();
    test_no_idling();
    drain();

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tre_pkg.sv
rtl/tre_ctrl.sv
rtl/tre_dp.sv
rtl/tcp_rto_estimator.sv
bench/tb_tcp_rto_estimator.sv
